[rtl/macd_pkg.sv]
// Shared types, codes and constants of the MACD crossover signal block.
package macd_pkg;

  localparam int VolumeDepthDefault = 16;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 17;

  localparam logic [16:0] WeightOne = 17'd65536;
  localparam logic [16:0] FastWeightReset = 17'd10082;
  localparam logic [16:0] SlowWeightReset = 17'd4855;
  localparam logic [16:0] SignalWeightReset = 17'd13107;
  localparam logic [7:0] SinceSellMax = 8'd255;

  typedef enum logic [2:0] {
    CFG_FAST_WEIGHT   = 3'd0,
    CFG_SLOW_WEIGHT   = 3'd1,
    CFG_SIGNAL_WEIGHT = 3'd2,
    CFG_TRADE_MODES   = 3'd3,
    CFG_SELL_FRACTION = 3'd4,
    CFG_FILTER_FLAGS  = 3'd5,
    CFG_VOLUME_WINDOW = 3'd6,
    CFG_COOLDOWN      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_BUY   = 2'd1,
    ACT_SELL  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SELL_DEATH_CROSS = 2'd0,
    SELL_DIF_ZERO    = 2'd1,
    SELL_BELOW_LIMIT = 2'd2,
    SELL_HIST_FALL   = 2'd3
  } exit_rule_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FAST,
    S_SLOW,
    S_DIF,
    S_SIG,
    S_HIST,
    S_THR,
    S_SUM,
    S_VOL,
    S_DECIDE
  } state_t;

  function automatic logic [16:0] clamp_weight(input logic [16:0] w);
    return (w > WeightOne) ? WeightOne : w;
  endfunction

endpackage

[rtl/macd_if.sv]
// Handshake channels of the MACD crossover signal block: bars, results, configuration.
interface macd_bar_if;
  logic        valid;
  logic        ready;
  logic [31:0] close_price;
  logic [31:0] bar_volume;
  logic        first_bar;
  logic        last_bar;

  modport source(output valid, close_price, bar_volume, first_bar, last_bar, input ready);
  modport sink(input valid, close_price, bar_volume, first_bar, last_bar, output ready);
endinterface

interface macd_result_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] macd_line;
  logic signed [32:0] signal_line;
  logic signed [32:0] histogram;
  logic [1:0]         action;
  logic               position_held;

  modport source(output valid, macd_line, signal_line, histogram, action, position_held,
                 input ready);
  modport sink(input valid, macd_line, signal_line, histogram, action, position_held,
               output ready);
endinterface

interface macd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [macd_pkg::CfgIndexW-1:0]  index;
  logic [macd_pkg::CfgDataW-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/macd_crossover_signal.sv]
// Top level of the MACD crossover signal block: sequencer, shared multiplier, volume ring.
// A bar steps from acceptance through the fast, slow, dif, signal, hist and thr states to
// the decide state (fast, slow and signal EMA steps, threshold and volume products all go
// through one shared 34x18 multiplier), and via the sum and vol states to sum the volume
// window of n bars and form the volume product when a buy is being checked with the volume
// filter on; the first bar of a series goes straight to the decide state. The block takes
// one bar at a time; a finished result waits in the output register while the next
// bar is accepted, and a bar whose result finds that register still full stalls until it
// is taken. The user is to write configuration between bars, which the block does not
// enforce, through an always-ready channel; such a write takes effect on the next bar.
module macd_crossover_signal #(
  parameter int VOLUME_DEPTH = macd_pkg::VolumeDepthDefault
) (
  input logic           clk,
  input logic           rst,
  macd_bar_if.sink      bar,
  macd_result_if.source result,
  macd_cfg_if.sink      cfg
);

  localparam int AW = $clog2(VOLUME_DEPTH);
  localparam int CW = $clog2(VOLUME_DEPTH + 1);
  localparam int PW = CW + 1;
  localparam int SW = 32 + CW;
  localparam int NBW = CW + 3;

  // configuration registers
  logic [16:0] fast_weight, slow_weight, signal_weight;
  logic [2:0]  trade_modes;
  logic [15:0] sell_fraction;
  logic [1:0]  filter_flags;
  logic [4:0]  volume_window;
  logic [7:0]  cooldown_bars;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_weight   <= macd_pkg::FastWeightReset;
      slow_weight   <= macd_pkg::SlowWeightReset;
      signal_weight <= macd_pkg::SignalWeightReset;
      trade_modes   <= '0;
      sell_fraction <= '0;
      filter_flags  <= '0;
      volume_window <= '0;
      cooldown_bars <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (macd_pkg::cfg_reg_t'(cfg.index))
        macd_pkg::CFG_FAST_WEIGHT:   fast_weight   <= cfg.data;
        macd_pkg::CFG_SLOW_WEIGHT:   slow_weight   <= cfg.data;
        macd_pkg::CFG_SIGNAL_WEIGHT: signal_weight <= cfg.data;
        macd_pkg::CFG_TRADE_MODES:   trade_modes   <= cfg.data[2:0];
        macd_pkg::CFG_SELL_FRACTION: sell_fraction <= cfg.data[15:0];
        macd_pkg::CFG_FILTER_FLAGS:  filter_flags  <= cfg.data[1:0];
        macd_pkg::CFG_VOLUME_WINDOW: volume_window <= cfg.data[4:0];
        macd_pkg::CFG_COOLDOWN:      cooldown_bars <= cfg.data[7:0];
      endcase
    end
  end

  // effective window length, clamped to the ring depth
  logic [31:0]   vw_ext;
  logic [CW-1:0] nwin;
  logic [NBW-1:0] nwin_x5;
  assign vw_ext  = {27'd0, volume_window};
  assign nwin    = (vw_ext > VOLUME_DEPTH) ? CW'(VOLUME_DEPTH) : vw_ext[CW-1:0];
  assign nwin_x5 = NBW'({nwin, 2'b00}) + NBW'(nwin);

  // sequencer
  macd_pkg::state_t state, state_next;
  logic go_out;

  // bar registers and series state
  logic [31:0]        close_q, vol_q;
  logic               restart_q, last_q, vneed;
  logic [31:0]        fast_avg, slow_avg;
  logic signed [32:0] sig_avg, prev_macd, prev_hist;
  logic signed [32:0] dif, dea, hist;
  logic [31:0]        thr;
  logic [51:0]        vol_prod;
  logic               holding;
  logic [7:0]         since_sell;
  logic [CW-1:0]      bar_count;
  logic [AW-1:0]      ring_pos;
  logic [SW-1:0]      acc;
  logic [CW-1:0]      cnt;
  logic               pend;

  // volume ring
  logic [31:0]   ring [VOLUME_DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_tmp;

  assign rd_tmp  = PW'(ring_pos) + PW'(VOLUME_DEPTH - 1) - PW'(cnt);
  assign rd_addr = (rd_tmp >= PW'(VOLUME_DEPTH)) ? AW'(rd_tmp - PW'(VOLUME_DEPTH))
                                                 : AW'(rd_tmp);

  assign go_out = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= macd_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    bar.ready  = 1'b0;
    unique case (state)
      macd_pkg::S_IDLE: begin
        bar.ready = 1'b1;
        if (bar.valid) begin
          state_next = (bar.first_bar || bar_count == '0) ? macd_pkg::S_DECIDE
                                                         : macd_pkg::S_FAST;
        end
      end
      macd_pkg::S_FAST: state_next = macd_pkg::S_SLOW;
      macd_pkg::S_SLOW: state_next = macd_pkg::S_DIF;
      macd_pkg::S_DIF:  state_next = macd_pkg::S_SIG;
      macd_pkg::S_SIG:  state_next = macd_pkg::S_HIST;
      macd_pkg::S_HIST: state_next = macd_pkg::S_THR;
      macd_pkg::S_THR:  state_next = vneed ? macd_pkg::S_SUM : macd_pkg::S_DECIDE;
      macd_pkg::S_SUM: begin
        if (cnt == nwin && !pend) state_next = macd_pkg::S_VOL;
      end
      macd_pkg::S_VOL:  state_next = macd_pkg::S_DECIDE;
      macd_pkg::S_DECIDE: begin
        if (go_out) state_next = macd_pkg::S_IDLE;
      end
      default: state_next = macd_pkg::S_IDLE;
    endcase
  end

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [35:0] ema_inc;
  logic signed [36:0] ema_base, ema_sum;

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    ema_base = '0;
    unique case (state)
      macd_pkg::S_FAST: begin
        mul_a    = $signed({2'b00, close_q}) - $signed({2'b00, fast_avg});
        mul_b    = $signed({1'b0, macd_pkg::clamp_weight(fast_weight)});
        ema_base = $signed({5'b00000, fast_avg});
      end
      macd_pkg::S_SLOW: begin
        mul_a    = $signed({2'b00, close_q}) - $signed({2'b00, slow_avg});
        mul_b    = $signed({1'b0, macd_pkg::clamp_weight(slow_weight)});
        ema_base = $signed({5'b00000, slow_avg});
      end
      macd_pkg::S_SIG: begin
        mul_a    = $signed({dif[32], dif}) - $signed({sig_avg[32], sig_avg});
        mul_b    = $signed({1'b0, macd_pkg::clamp_weight(signal_weight)});
        ema_base = 37'(sig_avg);
      end
      macd_pkg::S_THR: begin
        mul_a = $signed({2'b00, close_q});
        mul_b = $signed({2'b00, sell_fraction});
      end
      macd_pkg::S_VOL: begin
        mul_a = $signed({2'b00, vol_q});
        mul_b = $signed(18'(nwin_x5));
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign ema_inc = prod[51:16];
  assign ema_sum = ema_base + 37'(ema_inc);

  // histogram with saturation
  logic signed [33:0] hist_full;
  logic signed [32:0] hist_sat;
  assign hist_full = $signed({dif[32], dif}) - $signed({dea[32], dea});
  always_comb begin
    if (hist_full[33] != hist_full[32]) begin
      hist_sat = hist_full[33] ? 33'sh1_0000_0000 : 33'sh0_FFFF_FFFF;
    end else begin
      hist_sat = hist_full[32:0];
    end
  end

  // buy / sell decision
  logic [SW+2:0]        acc6;
  logic                 vol_fail, buy_ok, sell_now;
  logic                 hist_gt0, hist_lt0, prev_hist_le0, prev_hist_ge0;
  logic [1:0]           act;
  logic                 hold_next;
  logic [7:0]           since_next;
  macd_pkg::exit_rule_t exit_rule;

  assign acc6          = {acc, 2'b00} + {1'b0, acc, 1'b0};
  assign vol_fail      = vol_prod < 52'(acc6);
  assign hist_gt0      = !hist[32] && hist != '0;
  assign hist_lt0      = hist[32];
  assign prev_hist_le0 = prev_hist[32] || prev_hist == '0;
  assign prev_hist_ge0 = !prev_hist[32];
  assign exit_rule     = macd_pkg::exit_rule_t'(trade_modes[2:1]);

  always_comb begin
    buy_ok = prev_hist_le0 && hist_gt0;
    if (filter_flags[0] && !dif[32]) buy_ok = 1'b0;
    if (filter_flags[1] && bar_count >= CW'(2) && dif <= prev_macd) buy_ok = 1'b0;
    if (vneed && vol_fail) buy_ok = 1'b0;
    if (since_sell < cooldown_bars) buy_ok = 1'b0;

    unique case (exit_rule)
      macd_pkg::SELL_DIF_ZERO:    sell_now = !prev_macd[32] && dif[32];
      macd_pkg::SELL_BELOW_LIMIT: sell_now = $signed({dif[32], dif}) < -$signed({2'b00, thr});
      macd_pkg::SELL_DEATH_CROSS,
      macd_pkg::SELL_HIST_FALL:   sell_now = prev_hist_ge0 && hist_lt0;
    endcase

    act        = macd_pkg::ACT_NONE;
    hold_next  = holding;
    since_next = since_sell;
    priority if (restart_q) begin
      hold_next  = 1'b0;
      since_next = macd_pkg::SinceSellMax;
    end else if (last_q) begin
      if (holding) begin
        act       = macd_pkg::ACT_CLOSE;
        hold_next = 1'b0;
      end
    end else if (!holding) begin
      if (buy_ok) begin
        act       = macd_pkg::ACT_BUY;
        hold_next = 1'b1;
      end else if (since_sell != macd_pkg::SinceSellMax) begin
        since_next = since_sell + 8'd1;
      end
    end else if (sell_now) begin
      act        = macd_pkg::ACT_SELL;
      hold_next  = 1'b0;
      since_next = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      holding      <= 1'b0;
      since_sell   <= macd_pkg::SinceSellMax;
      bar_count    <= '0;
      ring_pos     <= '0;
      result.valid <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (state == macd_pkg::S_DECIDE && go_out) result.valid <= 1'b1;
      else if (result.ready)                      result.valid <= 1'b0;
      unique case (state)
        macd_pkg::S_HIST: pend <= 1'b0;
        macd_pkg::S_SUM:  pend <= (cnt != nwin);
        macd_pkg::S_DECIDE: begin
          if (go_out) begin
            holding      <= hold_next;
            since_sell   <= since_next;
            if (restart_q) begin
              bar_count <= CW'(1);
              ring_pos  <= AW'(1);
            end else begin
              if (bar_count < CW'(VOLUME_DEPTH)) bar_count <= bar_count + CW'(1);
              ring_pos <= (ring_pos == AW'(VOLUME_DEPTH - 1)) ? '0 : ring_pos + AW'(1);
            end
          end
        end
        default: pend <= pend;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    unique case (state)
      macd_pkg::S_IDLE: begin
        if (bar.valid) begin
          close_q   <= bar.close_price;
          vol_q     <= bar.bar_volume;
          restart_q <= bar.first_bar || bar_count == '0;
          last_q    <= bar.last_bar;
        end
      end
      macd_pkg::S_FAST: fast_avg <= ema_sum[31:0];
      macd_pkg::S_SLOW: slow_avg <= ema_sum[31:0];
      macd_pkg::S_DIF:  dif <= $signed({1'b0, fast_avg}) - $signed({1'b0, slow_avg});
      macd_pkg::S_SIG:  dea <= (bar_count == CW'(1)) ? dif : ema_sum[32:0];
      macd_pkg::S_HIST: begin
        hist  <= hist_sat;
        vneed <= !last_q && !holding && nwin != '0 && bar_count >= nwin;
        acc   <= '0;
        cnt   <= '0;
      end
      macd_pkg::S_THR:  thr <= prod[47:16];
      macd_pkg::S_SUM: begin
        if (cnt != nwin) cnt <= cnt + CW'(1);
        if (pend) acc <= acc + SW'(rd_data);
      end
      macd_pkg::S_VOL:  vol_prod <= prod;
      macd_pkg::S_DECIDE: begin
        if (go_out) begin
          if (restart_q) begin
            fast_avg             <= close_q;
            slow_avg             <= close_q;
            sig_avg              <= '0;
            prev_macd            <= '0;
            prev_hist            <= '0;
            result.macd_line     <= '0;
            result.signal_line   <= '0;
            result.histogram     <= '0;
          end else begin
            sig_avg              <= dea;
            prev_macd            <= dif;
            prev_hist            <= hist;
            result.macd_line     <= dif;
            result.signal_line   <= dea;
            result.histogram     <= hist;
          end
          result.action        <= act;
          result.position_held <= hold_next;
        end
      end
      default: cnt <= cnt;
    endcase
  end

  // ring write on result, read one entry a cycle while summing
  always_ff @(posedge clk) begin
    if (state == macd_pkg::S_DECIDE && go_out) begin
      ring[restart_q ? '0 : ring_pos] <= vol_q;
    end
    rd_data <= ring[rd_addr];
  end

endmodule

[rtl/macd_check.sv]
// Port-level assertions for the MACD crossover signal block and their binding.
module macd_check (
  input logic       clk,
  input logic       rst,
  input logic       bar_valid,
  input logic       bar_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] action,
  input logic       position_held
);

  // a pending result stays offered until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transaction");

  // one bar at a time: busy right after taking a bar
  a_busy: assert property (@(posedge clk) disable iff (rst)
    bar_valid && bar_ready |=> !bar_ready)
    else $error("bar taken while previous bar in progress");

  a_buy_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == macd_pkg::ACT_BUY |-> position_held)
    else $error("buy without position");

  a_exit_flat: assert property (@(posedge clk) disable iff (rst)
    res_valid && (action == macd_pkg::ACT_SELL || action == macd_pkg::ACT_CLOSE)
      |-> !position_held)
    else $error("sell or close out still holding");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

endmodule

bind macd_crossover_signal macd_check u_macd_check (
  .clk          (clk),
  .rst          (rst),
  .bar_valid    (bar.valid),
  .bar_ready    (bar.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .action       (result.action),
  .position_held(result.position_held)
);
